FILE: sv/assert_macros.svh
// Assertion macros shared by the frame parser and the top-level RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: sv/fdsc_pkg.sv
// Types and constants of the framed decimal speed compare block.
package fdsc_pkg;

    localparam int SPEED_W        = 16;
    localparam int VALUE_W        = 14;
    localparam int BYTE_W         = 8;
    localparam int MAX_DIGITS_DEF = 4;

    localparam logic [BYTE_W-1:0]  CH_OPEN   = 8'h7B;
    localparam logic [BYTE_W-1:0]  CH_CLOSE  = 8'h7D;
    localparam logic [BYTE_W-1:0]  CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0]  CH_NINE   = 8'h39;
    localparam logic [SPEED_W-1:0] TOL_RESET = 16'd30;

    localparam logic [1:0] LED_NONE   = 2'b00;
    localparam logic [1:0] LED_LOCAL  = 2'b01;
    localparam logic [1:0] LED_REMOTE = 2'b10;
    localparam logic [1:0] LED_MATCH  = 2'b11;

    typedef enum logic [1:0] {
        ST_IGNORED  = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_ABORTED  = 2'd3
    } frame_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  rx_byte;
        logic [SPEED_W-1:0] meas_speed;
    } item_word_t;

    typedef struct packed {
        frame_status_t      frame_status;
        logic [1:0]         led_mask;
        logic [VALUE_W-1:0] received_value;
    } result_word_t;

    typedef struct packed {
        logic [SPEED_W-1:0] match_tolerance;
    } cfg_word_t;

    typedef struct packed {
        frame_status_t      status;
        logic               complete;
        logic [VALUE_W-1:0] value;
    } frame_dec_t;

endpackage

FILE: sv/fdsc_if.sv
// Valid/ready channel interfaces for item, result and configuration words.
interface fdsc_item_if
    import fdsc_pkg::*;
();
    logic       valid;
    logic       ready;
    item_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fdsc_result_if
    import fdsc_pkg::*;
();
    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fdsc_cfg_if
    import fdsc_pkg::*;
();
    logic      valid;
    logic      ready;
    cfg_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/fdsc_frame.sv
// Frame parser: brace/digit decode and frame state.
`include "assert_macros.svh"

module fdsc_frame
    import fdsc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    output frame_dec_t        dec
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic               in_frame_reg;
    logic               in_frame_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [VALUE_W-1:0] accum_reg;
    logic [VALUE_W-1:0] accum_next;

    logic               is_digit;
    logic [3:0]         digit;
    logic [VALUE_W-1:0] accum_digit;

    assign is_digit    = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign digit       = 4'(rx_byte - CH_ZERO);
    assign accum_digit = VALUE_W'({accum_reg, 3'b000}) + VALUE_W'({accum_reg, 1'b0})
                       + VALUE_W'(digit);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        accum_next    = accum_reg;
        dec.status    = ST_IGNORED;
        dec.complete  = 1'b0;
        dec.value     = accum_reg;
        if (rx_byte == CH_OPEN)
        begin
            in_frame_next = 1'b1;
            count_next    = '0;
            accum_next    = '0;
            dec.status    = ST_ACCEPTED;
        end
        else if (!in_frame_reg)
        begin
            dec.status = ST_IGNORED;
        end
        else if (is_digit && (count_reg < CNT_W'(MAX_DIGITS)))
        begin
            accum_next = accum_digit;
            count_next = count_reg + CNT_W'(1);
            dec.status = ST_ACCEPTED;
        end
        else if ((rx_byte == CH_CLOSE) && (count_reg != '0))
        begin
            in_frame_next = 1'b0;
            count_next    = '0;
            accum_next    = '0;
            dec.status    = ST_COMPLETE;
            dec.complete  = 1'b1;
        end
        else
        begin
            in_frame_next = 1'b0;
            count_next    = '0;
            accum_next    = '0;
            dec.status    = ST_ABORTED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            accum_reg    <= '0;
        end
        else if (step)
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            accum_reg    <= accum_next;
        end
    end

    `ASSERT_NEVER(a_count_max, clk, rst_n, count_reg > CNT_W'(MAX_DIGITS))
    `ASSERT_IMPLIES(a_idle_clear, clk, rst_n, !in_frame_reg, (count_reg == '0) && (accum_reg == '0))
    `ASSERT_NEXT(a_hold, clk, rst_n, !step, $stable(count_reg) && $stable(accum_reg))

endmodule

FILE: sv/fdsc_speed_cmp.sv
// Speed comparator: absolute difference against tolerance, picks indicator bits.
module fdsc_speed_cmp
    import fdsc_pkg::*;
(
    input  logic [SPEED_W-1:0] meas_speed,
    input  logic [VALUE_W-1:0] remote_speed,
    input  logic [SPEED_W-1:0] tolerance,
    output logic [1:0]         led_mask
);

    logic [SPEED_W-1:0] remote_ext;
    logic               local_faster;
    logic [SPEED_W-1:0] diff;

    assign remote_ext   = SPEED_W'(remote_speed);
    assign local_faster = meas_speed > remote_ext;
    assign diff         = local_faster ? (meas_speed - remote_ext) : (remote_ext - meas_speed);

    always_comb
    begin
        if (diff <= tolerance)
            led_mask = LED_MATCH;
        else if (local_faster)
            led_mask = LED_LOCAL;
        else
            led_mask = LED_REMOTE;
    end

endmodule

FILE: sv/framed_decimal_speed_compare.sv
// Framed decimal speed compare: top level with input and result registers.
// Each word passes the input register, then the result register; a full result register not taken stalls it.
// Throughput: 1 word per cycle; the input register advances whenever the
// result register is empty or being taken, so both stages stream together.
// Reset: rst_n async low clears frame state and valid flags, and sets tolerance to 30.
`include "assert_macros.svh"

module framed_decimal_speed_compare
    import fdsc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    fdsc_item_if.sink      item,
    fdsc_result_if.source  result,
    fdsc_cfg_if.sink       cfg
);

    logic               s1_valid_reg;
    item_word_t         s1_word_reg;
    logic               s1_adv;
    logic               s1_stall;
    logic               out_valid_reg;
    result_word_t       out_word_reg;
    result_word_t       out_word_next;
    logic [SPEED_W-1:0] tol_reg;
    frame_dec_t         dec;
    logic [1:0]         cmp_mask;
    logic               out_complete;
    logic               out_other;
    logic               out_blank;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign s1_stall   = s1_valid_reg && !s1_adv;
    assign item.ready = !s1_valid_reg || s1_adv;
    assign cfg.ready  = 1'b1;

    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

    assign out_complete = out_valid_reg && (out_word_reg.frame_status == ST_COMPLETE);
    assign out_other    = out_valid_reg && (out_word_reg.frame_status != ST_COMPLETE);
    assign out_blank    = (out_word_reg.led_mask == LED_NONE) && (out_word_reg.received_value == '0);

    fdsc_frame #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_adv),
        .rx_byte (s1_word_reg.rx_byte),
        .dec     (dec)
    );

    fdsc_speed_cmp u_cmp (
        .meas_speed   (s1_word_reg.meas_speed),
        .remote_speed (dec.value),
        .tolerance    (tol_reg),
        .led_mask     (cmp_mask)
    );

    always_comb
    begin
        out_word_next.frame_status   = dec.status;
        out_word_next.led_mask       = dec.complete ? cmp_mask : LED_NONE;
        out_word_next.received_value = dec.complete ? dec.value : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tol_reg       <= TOL_RESET;
        end
        else
        begin
            if (item.ready)
                s1_valid_reg <= item.valid;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
                tol_reg <= cfg.data.match_tolerance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            s1_word_reg <= item.data;
        if (s1_adv)
            out_word_reg <= out_word_next;
    end

    `ASSERT_IMPLIES(a_ready_when_empty, clk, rst_n, !out_valid_reg, item.ready)
    `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_stall, s1_valid_reg && $stable(s1_word_reg))
    `ASSERT_IMPLIES(a_no_meaning, clk, rst_n, out_other, out_blank)
    `ASSERT_IMPLIES(a_complete_mask, clk, rst_n, out_complete, out_word_reg.led_mask != LED_NONE)

endmodule
